/* design/sogn_pkg.sv */
`default_nettype none
package sogn_pkg;

  localparam int COORD_BITS = 8;
  localparam int FRAC_BITS  = 15;
  localparam int VB         = 8;
  localparam int NVTX       = 8;
  localparam int VIDX_W     = 3;
  localparam int VTX_W      = 32;

  // Edge geometry widths
  localparam int CW  = 2 * VB + 1;
  localparam int EW  = VB + COORD_BITS + 2;
  localparam int DW  = EW + 1;
  localparam int QW  = CW + EW + 1;
  localparam int NW  = DW + EW;

  // Axis scaling widths
  localparam int AW    = 2 * COORD_BITS;
  localparam int QAW   = 2 * FRAC_BITS + 1;
  localparam int UW    = FRAC_BITS + 1;
  localparam int PW    = 2 * UW;
  localparam int OUT_W = 16;
  localparam int SHIFT = 2 * FRAC_BITS - 15;
  localparam logic [OUT_W-1:0] OUT_MAX = 16'd32767;

  localparam logic [NVTX-1:0][VTX_W-1:0] VTX_RESET = {
    32'd1086325757, 32'd11927804, 32'd3233873405, 32'd2902522624,
    32'd3225484547, 32'd4849668, 32'd1077936899, 32'd1392510208
  };

  typedef struct packed {
    logic signed [COORD_BITS-1:0] raw_x;
    logic signed [COORD_BITS-1:0] raw_y;
  } in_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] norm_x;
    logic signed [OUT_W-1:0] norm_y;
  } out_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
  } side_t;

  typedef struct packed {
    logic [UW-1:0] fq;
    side_t         side;
  } axtag_t;

  // magnitude of a signed coordinate; the most negative value maps to 2^(n-1)
  function automatic logic [COORD_BITS-1:0] mag(input logic signed [COORD_BITS-1:0] v);
    logic [COORD_BITS-1:0] u;
    u = v;
    return v[COORD_BITS-1] ? (~u + 1'b1) : u;
  endfunction

  // byte sel of a packed vertex word: 0 inner x, 1 inner y, 2 outer x, 3 outer y
  function automatic logic signed [VB-1:0] vc(input logic [VTX_W-1:0] w, input int sel);
    return w[VB*sel +: VB];
  endfunction

endpackage
`default_nettype wire

/* design/sogn_fdiv.sv */
`default_nettype none
// Pipelined restoring fraction divider: quo = floor(num * 2^STEPS / den), num <= den.
module sogn_fdiv #(
  parameter int BW    = 16,
  parameter int STEPS = 30,
  parameter int PER   = 2,
  parameter int TW    = 1
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             in_valid,
  input  logic [BW-1:0]    num,
  input  logic [BW-1:0]    den,
  input  logic [TW-1:0]    in_tag,
  output logic             out_valid,
  output logic [STEPS:0]   quo,
  output logic [TW-1:0]    out_tag
);

  localparam int NS = (STEPS + PER - 1) / PER;

  logic [NS:0]       vld;
  logic [BW-1:0]     rem   [NS+1];
  logic [BW-1:0]     dv    [NS+1];
  logic [STEPS:0]    qt    [NS+1];
  logic [TW-1:0]     tg    [NS+1];
  logic [BW-1:0]     rem_next [NS];
  logic [STEPS:0]    qt_next  [NS];

  always_comb begin
    logic [BW:0]    sh;
    logic [BW-1:0]  r;
    logic [STEPS:0] q;
    sh = '0;
    for (int s = 0; s < NS; s++) begin
      r = rem[s];
      q = qt[s];
      for (int k = 0; k < PER; k++) begin
        if (s * PER + k < STEPS) begin
          sh = {r, 1'b0};
          if (sh >= {1'b0, dv[s]}) begin
            sh = sh - {1'b0, dv[s]};
            q  = {q[STEPS-1:0], 1'b1};
          end else begin
            q  = {q[STEPS-1:0], 1'b0};
          end
          r = sh[BW-1:0];
        end
      end
      rem_next[s] = r;
      qt_next[s]  = q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NS-1:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // integer part first: one when num reaches den
      if (num >= den) begin
        qt[0]  <= (STEPS+1)'(1);
        rem[0] <= num - den;
      end else begin
        qt[0]  <= '0;
        rem[0] <= num;
      end
      dv[0] <= den;
      tg[0] <= in_tag;
      for (int s = 0; s < NS; s++) begin
        rem[s+1] <= rem_next[s];
        qt[s+1]  <= qt_next[s];
        dv[s+1]  <= dv[s];
        tg[s+1]  <= tg[s];
      end
    end
  end

  assign out_valid = vld[NS];
  assign quo       = qt[NS];
  assign out_tag   = tg[NS];

endmodule
`default_nettype wire

/* design/sogn_isqrt.sv */
`default_nettype none
// Pipelined integer square root, PER result bits per stage.
module sogn_isqrt #(
  parameter int IW  = 31,
  parameter int PER = 2,
  parameter int TW  = 1
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  logic                  in_valid,
  input  logic [IW-1:0]         val,
  input  logic [TW-1:0]         in_tag,
  output logic                  out_valid,
  output logic [(IW+1)/2-1:0]   root,
  output logic [TW-1:0]         out_tag
);

  localparam int RW = (IW + 1) / 2;
  localparam int SW = IW + 1;
  localparam int NS = (RW + PER - 1) / PER;

  logic [NS:0]   vld;
  logic [SW-1:0] v    [NS+1];
  logic [SW-1:0] rs   [NS+1];
  logic [TW-1:0] tg   [NS+1];
  logic [SW-1:0] v_next  [NS];
  logic [SW-1:0] rs_next [NS];

  always_comb begin
    logic [SW-1:0] vv;
    logic [SW-1:0] rr;
    logic [SW-1:0] bt;
    logic [SW-1:0] t;
    int            j;
    bt = '0;
    t  = '0;
    for (int s = 0; s < NS; s++) begin
      vv = v[s];
      rr = rs[s];
      for (int k = 0; k < PER; k++) begin
        j = s * PER + k;
        if (j < RW) begin
          bt = SW'(1) << (2 * (RW - 1 - j));
          t  = rr + bt;
          if (vv >= t) begin
            vv = vv - t;
            rr = (rr >> 1) + bt;
          end else begin
            rr = rr >> 1;
          end
        end
      end
      v_next[s]  = vv;
      rs_next[s] = rr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NS-1:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      v[0]  <= SW'(val);
      rs[0] <= '0;
      tg[0] <= in_tag;
      for (int s = 0; s < NS; s++) begin
        v[s+1]  <= v_next[s];
        rs[s+1] <= rs_next[s];
        tg[s+1] <= tg[s];
      end
    end
  end

  assign out_valid = vld[NS];
  assign root      = rs[NS][RW-1:0];
  assign out_tag   = tg[NS];

endmodule
`default_nettype wire

/* design/sogn_geom.sv */
`default_nettype none
// Octant pick and ray/edge crossing for both octagons; emits the clamped
// fraction as num/den with num <= den (num = 0, den = 1 when degenerate).
module sogn_geom (
  input  logic                                            clk,
  input  logic                                            rst,
  input  logic                                            en,
  input  logic                                            in_valid,
  input  sogn_pkg::in_t                                   sample,
  input  logic [sogn_pkg::NVTX-1:0][sogn_pkg::VTX_W-1:0]  vtx,
  output logic                                            out_valid,
  output logic [sogn_pkg::NW-1:0]                         num,
  output logic [sogn_pkg::NW-1:0]                         den,
  output sogn_pkg::side_t                                 side
);

  localparam int CB = sogn_pkg::COORD_BITS;
  localparam int VB = sogn_pkg::VB;
  localparam int CW = sogn_pkg::CW;
  localparam int EW = sogn_pkg::EW;
  localparam int DW = sogn_pkg::DW;
  localparam int QW = sogn_pkg::QW;
  localparam int NW = sogn_pkg::NW;

  logic [5:0] vld;

  // stage 1: octant and vertex pair
  logic [CB-1:0] ax, ay;
  logic          steep;
  logic [1:0]    quad;
  logic [2:0]    oct, nxt;

  always_comb begin
    ax    = sogn_pkg::mag(sample.raw_x);
    ay    = sogn_pkg::mag(sample.raw_y);
    steep = ax <= ay;
    quad  = sample.raw_x[CB-1] ? (sample.raw_y[CB-1] ? 2'd2 : 2'd3)
                               : (sample.raw_y[CB-1] ? 2'd1 : 2'd0);
    oct   = {quad, steep ^ ~quad[0]};
    nxt   = oct + 3'd1;
  end

  logic [sogn_pkg::VTX_W-1:0] s1_wa, s1_wb;
  sogn_pkg::side_t            s1_side;

  // stage 2: cross products
  logic signed [VB-1:0] i1x, i1y, i2x, i2y, o1x, o1y, o2x, o2y;
  logic signed [VB:0]   dix, diy, dox, doy;

  assign i1x = sogn_pkg::vc(s1_wa, 0);
  assign i1y = sogn_pkg::vc(s1_wa, 1);
  assign o1x = sogn_pkg::vc(s1_wa, 2);
  assign o1y = sogn_pkg::vc(s1_wa, 3);
  assign i2x = sogn_pkg::vc(s1_wb, 0);
  assign i2y = sogn_pkg::vc(s1_wb, 1);
  assign o2x = sogn_pkg::vc(s1_wb, 2);
  assign o2y = sogn_pkg::vc(s1_wb, 3);
  assign dix = i1x - i2x;
  assign diy = i1y - i2y;
  assign dox = o1x - o2x;
  assign doy = o1y - o2y;

  logic signed [2*VB-1:0] s2_cia, s2_cib, s2_coa, s2_cob;
  logic signed [EW-2:0]   s2_eia, s2_eib, s2_eoa, s2_eob;
  sogn_pkg::side_t        s2_side;

  // stage 3
  logic signed [CW-1:0] s3_ci, s3_co;
  logic signed [EW-1:0] s3_ei, s3_eo;
  sogn_pkg::side_t      s3_side;

  // stage 4
  logic signed [DW-1:0]    dn;
  logic signed [NW-1:0]    s4_n;
  logic signed [CW+EW-1:0] s4_p1, s4_p2;
  logic                    s4_zero;
  sogn_pkg::side_t         s4_side;

  assign dn = s3_ei - s3_ci;

  // stage 5
  logic signed [QW-1:0] s5_q;
  logic signed [NW-1:0] s5_n;
  logic                 s5_zero;
  sogn_pkg::side_t      s5_side;

  // stage 6: fold sign of the span into the numerator, clamp to [0, 1]
  logic signed [NW-1:0] qe, qa, na;
  logic [NW-1:0]        num_next, den_next;

  always_comb begin
    qe = NW'(s5_q);
    qa = qe[NW-1] ? -qe : qe;
    na = qe[NW-1] ? -s5_n : s5_n;
    if (s5_zero || s5_q == '0) begin
      num_next = '0;
      den_next = NW'(1);
    end else begin
      den_next = qa;
      if (na <= 0) begin
        num_next = '0;
      end else if (na >= qa) begin
        num_next = qa;
      end else begin
        num_next = na;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[4:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_wa   <= vtx[oct];
      s1_wb   <= vtx[nxt];
      s1_side <= '{x: sample.raw_x, y: sample.raw_y};

      s2_cia  <= i1x * i2y;
      s2_cib  <= i1y * i2x;
      s2_coa  <= o1x * o2y;
      s2_cob  <= o1y * o2x;
      s2_eia  <= dix * s1_side.y;
      s2_eib  <= diy * s1_side.x;
      s2_eoa  <= dox * s1_side.y;
      s2_eob  <= doy * s1_side.x;
      s2_side <= s1_side;

      s3_ci   <= s2_cia - s2_cib;
      s3_co   <= s2_coa - s2_cob;
      s3_ei   <= s2_eia - s2_eib;
      s3_eo   <= s2_eoa - s2_eob;
      s3_side <= s2_side;

      s4_n    <= dn * s3_eo;
      s4_p1   <= s3_co * s3_ei;
      s4_p2   <= s3_ci * s3_eo;
      s4_zero <= (s3_ei == '0) || (s3_eo == '0);
      s4_side <= s3_side;

      s5_q    <= s4_p1 - s4_p2;
      s5_n    <= s4_n;
      s5_zero <= s4_zero;
      s5_side <= s4_side;

      num     <= num_next;
      den     <= den_next;
      side    <= s5_side;
    end
  end

  assign out_valid = vld[5];

endmodule
`default_nettype wire

/* design/stick_octagon_gate_normalizer_unit.sv */
`default_nettype none
// Throughput: one item per cycle; the pipeline advances as a whole whenever the
//   output register is empty or being taken, so a full pipeline drains one item per cycle.
// Reset (rst, synchronous): clears all valid bits and loads the default octagon vertices.
module stick_octagon_gate_normalizer_unit #(
  parameter int STEPS_PER_STAGE = 2
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  sogn_pkg::in_t                  in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output sogn_pkg::out_t                 out_data,
  input  logic                           cfg_we,
  input  logic [sogn_pkg::VIDX_W-1:0]    cfg_index,
  input  logic [sogn_pkg::VTX_W-1:0]     cfg_data
);

  localparam int CB    = sogn_pkg::COORD_BITS;
  localparam int FRAC  = sogn_pkg::FRAC_BITS;
  localparam int NW    = sogn_pkg::NW;
  localparam int AW    = sogn_pkg::AW;
  localparam int QAW   = sogn_pkg::QAW;
  localparam int UW    = sogn_pkg::UW;
  localparam int PW    = sogn_pkg::PW;
  localparam int OUT_W = sogn_pkg::OUT_W;
  localparam logic [UW-1:0] FQ_ONE = UW'(1) << FRAC;

  // Vertex registers: byte 0 inner x, byte 1 inner y, byte 2 outer x, byte 3 outer y.
  logic [sogn_pkg::NVTX-1:0][sogn_pkg::VTX_W-1:0] vtx;

  always_ff @(posedge clk) begin
    if (rst) begin
      vtx <= sogn_pkg::VTX_RESET;
    end else if (cfg_we) begin
      vtx[cfg_index] <= cfg_data;
    end
  end

  // One enable for every stage: advance whenever the output slot frees up.
  // Bubbles travel as cleared valid bits, so a stall never drops or doubles an item.
  logic en;
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  // Geometry: octant, edge crossings, clamped fraction as num/den.
  logic                 g_valid;
  logic [NW-1:0]        g_num, g_den;
  sogn_pkg::side_t      g_side;

  sogn_geom u_geom (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (in_valid),
    .sample    (in_data),
    .vtx       (vtx),
    .out_valid (g_valid),
    .num       (g_num),
    .den       (g_den),
    .side      (g_side)
  );

  // Radial fraction fq in [0, 2^FRAC].
  logic                 f_valid;
  logic [UW-1:0]        f_fq;
  sogn_pkg::side_t      f_side;

  sogn_fdiv #(
    .BW    (NW),
    .STEPS (FRAC),
    .PER   (STEPS_PER_STAGE),
    .TW    ($bits(sogn_pkg::side_t))
  ) u_fdiv_frac (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (g_valid),
    .num       (g_num),
    .den       (g_den),
    .in_tag    (g_side),
    .out_valid (f_valid),
    .quo       (f_fq),
    .out_tag   (f_side)
  );

  // Squares and squared radius for the unit direction.
  logic [CB-1:0]        ax, ay;
  logic [AW-1:0]        ax2, ay2;
  logic                 sq_valid;
  logic [AW-1:0]        sq_ax2, sq_ay2, sq_r2;
  sogn_pkg::axtag_t     sq_tag;

  always_comb begin
    ax  = sogn_pkg::mag(f_side.x);
    ay  = sogn_pkg::mag(f_side.y);
    ax2 = ax * ax;
    ay2 = ay * ay;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_valid <= 1'b0;
    end else if (en) begin
      sq_valid <= f_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq_ax2 <= ax2;
      sq_ay2 <= ay2;
      sq_r2  <= ax2 + ay2;
      sq_tag <= '{fq: f_fq, side: f_side};
    end
  end

  // a^2 / r^2 as a 2*FRAC-bit fraction, one lane per axis; the x lane carries
  // the item's radial fraction and side data, the y lane runs in lockstep.
  logic                 dx_valid;
  logic [QAW-1:0]       dx_quo, dy_quo;
  sogn_pkg::axtag_t     dx_tag;

  sogn_fdiv #(
    .BW    (AW),
    .STEPS (2 * FRAC),
    .PER   (STEPS_PER_STAGE),
    .TW    ($bits(sogn_pkg::axtag_t))
  ) u_fdiv_x (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (sq_valid),
    .num       (sq_ax2),
    .den       (sq_r2),
    .in_tag    (sq_tag),
    .out_valid (dx_valid),
    .quo       (dx_quo),
    .out_tag   (dx_tag)
  );

  sogn_fdiv #(
    .BW    (AW),
    .STEPS (2 * FRAC),
    .PER   (STEPS_PER_STAGE),
    .TW    (1)
  ) u_fdiv_y (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (sq_valid),
    .num       (sq_ay2),
    .den       (sq_r2),
    .in_tag    (1'b0),
    .out_valid (),
    .quo       (dy_quo),
    .out_tag   ()
  );

  // Unit direction magnitudes |a|/r in Q(FRAC).
  logic                 rx_valid;
  logic [UW-1:0]        ux, uy;
  sogn_pkg::axtag_t     rx_tag;

  sogn_isqrt #(
    .IW  (QAW),
    .PER (STEPS_PER_STAGE),
    .TW  ($bits(sogn_pkg::axtag_t))
  ) u_isqrt_x (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (dx_valid),
    .val       (dx_quo),
    .in_tag    (dx_tag),
    .out_valid (rx_valid),
    .root      (ux),
    .out_tag   (rx_tag)
  );

  sogn_isqrt #(
    .IW  (QAW),
    .PER (STEPS_PER_STAGE),
    .TW  (1)
  ) u_isqrt_y (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (dx_valid),
    .val       (dy_quo),
    .in_tag    (1'b0),
    .out_valid (),
    .root      (uy),
    .out_tag   ()
  );

  // Scale direction by the radial fraction.
  logic                 m_valid;
  logic [PW-1:0]        m_px, m_py;
  sogn_pkg::side_t      m_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else if (en) begin
      m_valid <= rx_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_px   <= rx_tag.fq * ux;
      m_py   <= rx_tag.fq * uy;
      m_side <= rx_tag.side;
    end
  end

  // Truncate, saturate at +/-32767, restore the axis sign.
  function automatic logic [OUT_W-1:0] sat_sign(input logic [PW-1:0] p, input logic neg);
    logic [PW-1:0]    m;
    logic [OUT_W-1:0] c;
    m = p >> sogn_pkg::SHIFT;
    c = (m > PW'(sogn_pkg::OUT_MAX)) ? sogn_pkg::OUT_MAX : m[OUT_W-1:0];
    return neg ? (~c + 1'b1) : c;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= m_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data.norm_x <= sat_sign(m_px, m_side.x[CB-1]);
      out_data.norm_y <= sat_sign(m_py, m_side.y[CB-1]);
    end
  end

  a_rst_clear: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid set after reset");

  a_fq_range: assert property (@(posedge clk) disable iff (rst)
    f_valid |-> f_fq <= FQ_ONE)
    else $error("radial fraction above one");

  a_sign_x: assert property (@(posedge clk) disable iff (rst)
    (en && m_valid && m_side.x < 0) |=> out_data.norm_x <= 0)
    else $error("norm_x sign disagrees with raw_x");

  a_zero_x: assert property (@(posedge clk) disable iff (rst)
    (en && m_valid && m_side.x == '0) |=> out_data.norm_x == '0)
    else $error("norm_x nonzero for zero raw_x");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> ($stable(m_px) && $stable(sq_r2)))
    else $error("pipeline moved during stall");

endmodule
`default_nettype wire
